@@ hdl/assert_macros.svh @@
// assertion macros shared by the checker files
// no dependencies; expects clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, clocked, off during reset
`define FMD_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("fmd check failed");

// same-cycle implication
`define FMD_ASSERT_IMP(label, ante, cons) \
	`FMD_ASSERT(label, ante |-> cons)

// next-cycle implication
`define FMD_ASSERT_NXT(label, ante, cons) \
	`FMD_ASSERT(label, ante |=> cons)

`endif

@@ hdl/fmd_pkg.sv @@
// shared types, op codes and glyph font of the frame buffer draw engine
// no dependencies
package fmd_pkg;

	localparam int DEF_SCREEN_WIDTH  = 128;
	localparam int DEF_SCREEN_HEIGHT = 64;

	// signed coordinate width inside the engine
	localparam int CW = 12;

	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_PIXEL  = 3'd1;
	localparam logic [2:0] OP_CIRCLE = 3'd2;
	localparam logic [2:0] OP_FILL   = 3'd3;
	localparam logic [2:0] OP_RECT   = 3'd4;
	localparam logic [2:0] OP_GLYPH  = 3'd5;
	localparam logic [2:0] OP_READ   = 3'd6;

	typedef struct packed {
		logic [2:0]        op;
		logic signed [9:0] pos_x;
		logic signed [9:0] pos_y;
		logic [6:0]        radius;
		logic [7:0]        rect_width;
		logic [6:0]        rect_height;
		logic              color;
		logic [5:0]        slot;
		logic [9:0]        byte_index;
		logic              read_ok;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic [2:0] done_op;
	} res_t;

	// font slot of a character code, blank for unknown codes
	function automatic logic [5:0] glyph_slot(input logic [7:0] c);
		logic [5:0] s;
		s = 6'd0;
		if (c >= 8'h30 && c <= 8'h39) s = 6'(c - 8'h2F);
		else if (c >= 8'h41 && c <= 8'h5A) s = 6'(c - 8'h36);
		else if (c == 8'h2E) s = 6'd37;
		return s;
	endfunction

	// one 7-row column of a glyph, bit = row
	function automatic logic [6:0] glyph_col(input logic [5:0] slot, input logic [2:0] col);
		logic [39:0] g;
		logic [6:0]  r;
		case (slot)
			6'd1:  g = 40'h3E_51_49_45_3E;
			6'd2:  g = 40'h00_42_7F_40_00;
			6'd3:  g = 40'h42_61_51_49_46;
			6'd4:  g = 40'h21_41_45_4B_31;
			6'd5:  g = 40'h18_14_12_7F_10;
			6'd6:  g = 40'h27_45_45_45_39;
			6'd7:  g = 40'h3C_4A_49_49_30;
			6'd8:  g = 40'h01_71_09_05_03;
			6'd9:  g = 40'h36_49_49_49_36;
			6'd10: g = 40'h06_49_49_29_1E;
			6'd11: g = 40'h7E_11_11_11_7E;
			6'd12: g = 40'h7F_49_49_49_36;
			6'd13: g = 40'h3E_41_41_41_22;
			6'd14: g = 40'h7F_41_41_22_1C;
			6'd15: g = 40'h7F_49_49_49_41;
			6'd16: g = 40'h7F_09_09_09_01;
			6'd17: g = 40'h3E_41_49_49_7A;
			6'd18: g = 40'h7F_08_08_08_7F;
			6'd19: g = 40'h00_41_7F_41_00;
			6'd20: g = 40'h20_40_41_3F_01;
			6'd21: g = 40'h7F_08_14_22_41;
			6'd22: g = 40'h7F_40_40_40_40;
			6'd23: g = 40'h7F_02_0C_02_7F;
			6'd24: g = 40'h7F_04_08_10_7F;
			6'd25: g = 40'h3E_41_41_41_3E;
			6'd26: g = 40'h7F_09_09_09_06;
			6'd27: g = 40'h3E_41_51_21_5E;
			6'd28: g = 40'h7F_09_19_29_46;
			6'd29: g = 40'h46_49_49_49_31;
			6'd30: g = 40'h01_01_7F_01_01;
			6'd31: g = 40'h3F_40_40_40_3F;
			6'd32: g = 40'h1F_20_40_20_1F;
			6'd33: g = 40'h3F_40_38_40_3F;
			6'd34: g = 40'h63_14_08_14_63;
			6'd35: g = 40'h07_08_70_08_07;
			6'd36: g = 40'h61_51_49_45_43;
			6'd37: g = 40'h00_60_60_00_00;
			default: g = 40'h00_00_00_00_00;
		endcase
		case (col)
			3'd0: r = g[38:32];
			3'd1: r = g[30:24];
			3'd2: r = g[22:16];
			3'd3: r = g[14:8];
			3'd4: r = g[6:0];
			default: r = 7'd0;
		endcase
		return r;
	endfunction

endpackage

@@ hdl/fmd_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module fmd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/fmd_fifo.sv @@
// small register fifo, depth a power of two
// no dependencies
module fmd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [PW:0]      cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == (PW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= wdata;
	end

endmodule

@@ hdl/fmd_front.sv @@
// command front end: classifies items and queues them for the engine
// depends on fmd_pkg and fmd_fifo
module fmd_front #(
	parameter int SCREEN_WIDTH  = fmd_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = fmd_pkg::DEF_SCREEN_HEIGHT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [2:0]         op,
	input  logic signed [9:0]  pos_x,
	input  logic signed [9:0]  pos_y,
	input  logic [6:0]         radius,
	input  logic [7:0]         rect_width,
	input  logic [6:0]         rect_height,
	input  logic               color,
	input  logic [7:0]         char_code,
	input  logic [9:0]         byte_index,
	output logic               full,
	input  logic               cmd_pop,
	output fmd_pkg::cmd_t      cmd,
	output logic               cmd_empty
);

	localparam int STORE = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);

	fmd_pkg::cmd_t                   cin;
	logic [$bits(fmd_pkg::cmd_t)-1:0] qout;

	always_comb begin
		cin.op          = op;
		cin.pos_x       = pos_x;
		cin.pos_y       = pos_y;
		cin.radius      = radius;
		cin.rect_width  = rect_width;
		cin.rect_height = rect_height;
		cin.color       = color;
		cin.slot        = fmd_pkg::glyph_slot(char_code);
		cin.byte_index  = byte_index;
		cin.read_ok     = ({22'd0, byte_index} < 32'(STORE));
	end

	fmd_fifo #(
		.WIDTH($bits(fmd_pkg::cmd_t)),
		.DEPTH(2)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cin),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (qout),
		.empty (cmd_empty)
	);

	assign cmd = qout;

endmodule

@@ hdl/fmd_back.sv @@
// drawing engine: walks primitives pixel by pixel with read-modify-write
// depends on fmd_pkg and fmd_ram
module fmd_back #(
	parameter int SCREEN_WIDTH  = fmd_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = fmd_pkg::DEF_SCREEN_HEIGHT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_empty,
	input  fmd_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output fmd_pkg::res_t res,
	output logic          clearing
);

	localparam int STORE = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);
	localparam int AW    = $clog2(STORE);
	localparam int CW    = fmd_pkg::CW;

	typedef enum logic [4:0] {
		S_CLR  = 5'b00001,
		S_IDLE = 5'b00010,
		S_GEN  = 5'b00100,
		S_WR   = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic [AW-1:0] clr_q, clr_d;
	logic          boot_q, boot_d;

	fmd_pkg::cmd_t cmd_q;
	logic signed [8:0]  ox_q, oy_q, ox_n, oy_n;
	logic signed [11:0] oe_q, oe_n;
	logic [2:0]         k_q, k_n;
	logic signed [9:0]  fdx_q, fdy_q, fdx_n, fdy_n;
	logic [13:0]        rr_q;
	logic [7:0]         rj_q, rj_n;
	logic               rph_q, rph_n, rs_q, rs_n;
	logic [2:0]         gc_q, gr_q, gc_n, gr_n;
	logic               pdone_q, pdone_n;
	logic [AW-1:0]      waddr_q;
	logic [7:0]         wmask_q;
	logic               wcol_q;

	logic                 ram_we, ram_re;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [7:0]           ram_wdata, ram_rdata;

	logic signed [CW-1:0] cx, cy, ux, uy, ga, gb, rw_s, rh_s, rjs;
	logic signed [CW-1:0] pt_x, pt_y;
	logic                 pt_col, pt_v, pt_fin, on_scr;
	logic [AW-1:0]        paddr;
	logic [7:0]           pmask;
	logic                 swp, negx, negy;
	logic signed [8:0]    y1, x1;
	logic signed [9:0]    rf;
	logic signed [13:0]   e1, e2, tst;
	logic signed [17:0]   dx2, dy2, dsum;
	logic [6:0]           gbits;

	assign cx   = CW'(cmd_q.pos_x);
	assign cy   = CW'(cmd_q.pos_y);
	assign ux   = CW'(ox_q);
	assign uy   = CW'(oy_q);
	assign rw_s = $signed({4'd0, cmd_q.rect_width});
	assign rh_s = $signed({5'd0, cmd_q.rect_height});
	assign rjs  = $signed({4'd0, rj_q});
	assign rf   = $signed({3'b0, cmd_q.radius});

	// midpoint step of the outline
	always_comb begin
		y1  = oy_q + 9'sd1;
		e1  = 14'(oe_q) + (14'(y1) <<< 1) + 14'sd1;
		tst = (e1 <<< 1) - (14'(ox_q) <<< 1) + 14'sd1;
		x1  = (tst > 14'sd0) ? ox_q - 9'sd1 : ox_q;
		e2  = (tst > 14'sd0) ? e1 - (14'(x1) <<< 1) + 14'sd1 : e1;
	end

	// octant mirror of the outline point
	always_comb begin
		case (k_q) inside
			3'd1, 3'd2, 3'd5, 3'd6: swp = 1'b1;
			default:                swp = 1'b0;
		endcase
		case (k_q) inside
			3'd2, 3'd3, 3'd4, 3'd5: negx = 1'b1;
			default:                negx = 1'b0;
		endcase
		negy = k_q[2];
		ga   = swp ? uy : ux;
		gb   = swp ? ux : uy;
	end

	assign dx2   = fdx_q * fdx_q;
	assign dy2   = fdy_q * fdy_q;
	assign dsum  = dx2 + dy2;
	assign gbits = fmd_pkg::glyph_col(cmd_q.slot, gc_q);

	// current point of the active primitive and the step to the next one
	always_comb begin
		pt_x    = cx;
		pt_y    = cy;
		pt_col  = cmd_q.color;
		pt_v    = 1'b0;
		pt_fin  = 1'b1;
		ox_n    = ox_q;
		oy_n    = oy_q;
		oe_n    = oe_q;
		k_n     = k_q;
		fdx_n   = fdx_q;
		fdy_n   = fdy_q;
		rj_n    = rj_q;
		rph_n   = rph_q;
		rs_n    = rs_q;
		gc_n    = gc_q;
		gr_n    = gr_q;
		pdone_n = pdone_q;
		case (cmd_q.op)
			fmd_pkg::OP_PIXEL: begin
				pt_fin  = pdone_q;
				pt_v    = !pdone_q;
				pdone_n = 1'b1;
			end
			fmd_pkg::OP_CIRCLE: begin
				pt_fin = (ox_q < oy_q);
				pt_v   = !pt_fin;
				pt_x   = negx ? cx - ga : cx + ga;
				pt_y   = negy ? cy - gb : cy + gb;
				k_n    = k_q + 3'd1;
				if (k_q == 3'd7) begin
					oy_n = y1;
					ox_n = x1;
					oe_n = e2[11:0];
				end
			end
			fmd_pkg::OP_FILL: begin
				pt_fin = (fdy_q > rf);
				pt_v   = !pt_fin && (dsum <= $signed({4'd0, rr_q}));
				pt_x   = cx + CW'(fdx_q);
				pt_y   = cy + CW'(fdy_q);
				if (fdx_q >= rf) begin
					fdx_n = -rf;
					fdy_n = fdy_q + 10'sd1;
				end else begin
					fdx_n = fdx_q + 10'sd1;
				end
			end
			fmd_pkg::OP_RECT: begin
				if (!rph_q) begin
					pt_fin = 1'b0;
					if (rj_q < cmd_q.rect_width) begin
						pt_v = 1'b1;
						pt_x = cx + rjs;
						pt_y = rs_q ? cy + rh_s - 12'sd1 : cy;
						rs_n = !rs_q;
						if (rs_q) rj_n = rj_q + 8'd1;
					end else begin
						rph_n = 1'b1;
						rj_n  = '0;
						rs_n  = 1'b0;
					end
				end else if (rj_q < {1'b0, cmd_q.rect_height}) begin
					pt_fin = 1'b0;
					pt_v   = 1'b1;
					pt_x   = rs_q ? cx + rw_s - 12'sd1 : cx;
					pt_y   = cy + rjs;
					rs_n   = !rs_q;
					if (rs_q) rj_n = rj_q + 8'd1;
				end
			end
			fmd_pkg::OP_GLYPH: begin
				pt_fin = (gc_q == 3'd5);
				pt_v   = !pt_fin;
				pt_x   = cx + $signed({9'd0, gc_q});
				pt_y   = cy + $signed({9'd0, gr_q});
				pt_col = gbits[gr_q];
				if (gr_q == 3'd6) begin
					gr_n = '0;
					gc_n = gc_q + 3'd1;
				end else begin
					gr_n = gr_q + 3'd1;
				end
			end
			default: pt_fin = 1'b1;
		endcase
	end

	// clip and byte address
	always_comb begin
		on_scr = (pt_x >= 12'sd0) && (pt_x < $signed(CW'(SCREEN_WIDTH)))
			&& (pt_y >= 12'sd0) && (pt_y < $signed(CW'(SCREEN_HEIGHT)));
		paddr  = AW'(32'(pt_y[CW-2:3]) * 32'(SCREEN_WIDTH) + 32'(pt_x[CW-2:0]));
		pmask  = 8'd1 << pt_y[2:0];
	end

	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		boot_d    = boot_q;
		cmd_pop   = 1'b0;
		res_push  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = waddr_q;
		ram_wdata = wcol_q ? (ram_rdata | wmask_q) : (ram_rdata & ~wmask_q);
		ram_re    = 1'b0;
		ram_raddr = paddr;
		unique case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = 8'd0;
				clr_d     = clr_q + 1'b1;
				if (clr_q == AW'(STORE - 1)) begin
					clr_d   = '0;
					boot_d  = 1'b0;
					state_d = boot_q ? S_IDLE : S_DONE;
				end
			end
			S_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					case (cmd.op) inside
						fmd_pkg::OP_CLEAR: state_d = S_CLR;
						fmd_pkg::OP_READ: begin
							ram_re    = cmd.read_ok;
							ram_raddr = AW'(cmd.byte_index);
							state_d   = S_DONE;
						end
						fmd_pkg::OP_PIXEL, fmd_pkg::OP_CIRCLE, fmd_pkg::OP_FILL,
						fmd_pkg::OP_RECT, fmd_pkg::OP_GLYPH: state_d = S_GEN;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_GEN: begin
				if (pt_fin) begin
					state_d = S_DONE;
				end else if (pt_v && on_scr) begin
					ram_re  = 1'b1;
					state_d = S_WR;
				end
			end
			S_WR: begin
				ram_we  = 1'b1;
				state_d = S_GEN;
			end
			S_DONE: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			boot_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			boot_q  <= boot_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && !cmd_empty) begin
			cmd_q   <= cmd;
			ox_q    <= $signed({2'b0, cmd.radius});
			oy_q    <= '0;
			oe_q    <= '0;
			k_q     <= '0;
			fdx_q   <= -$signed({3'b0, cmd.radius});
			fdy_q   <= -$signed({3'b0, cmd.radius});
			rr_q    <= 14'(cmd.radius) * 14'(cmd.radius);
			rj_q    <= '0;
			rph_q   <= 1'b0;
			rs_q    <= 1'b0;
			gc_q    <= '0;
			gr_q    <= '0;
			pdone_q <= 1'b0;
		end else if (state_q == S_GEN && !pt_fin) begin
			ox_q    <= ox_n;
			oy_q    <= oy_n;
			oe_q    <= oe_n;
			k_q     <= k_n;
			fdx_q   <= fdx_n;
			fdy_q   <= fdy_n;
			rj_q    <= rj_n;
			rph_q   <= rph_n;
			rs_q    <= rs_n;
			gc_q    <= gc_n;
			gr_q    <= gr_n;
			pdone_q <= pdone_n;
			waddr_q <= paddr;
			wmask_q <= pmask;
			wcol_q  <= pt_col;
		end
	end

	fmd_ram #(
		.WIDTH(8),
		.DEPTH(STORE)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign res.done_op   = cmd_q.op;
	assign res.read_byte = (cmd_q.op == fmd_pkg::OP_READ && cmd_q.read_ok) ? ram_rdata : 8'd0;
	assign clearing      = boot_q;

endmodule

@@ hdl/monochrome_framebuffer_draw_engine.sv @@
// top level of the monochrome frame buffer draw engine
// depends on fmd_pkg, fmd_front, fmd_back, fmd_fifo
//
// a one-bit frame store of SCREEN_WIDTH x SCREEN_HEIGHT pixels, packed in pages
// of eight rows (byte = page*SCREEN_WIDTH + column, bit = row mod 8), driven by
// drawing commands. every item pushed returns exactly one result item, in order.
// after reset the store is swept to zero, one byte a cycle, over all
// SCREEN_WIDTH*pages bytes (1024 at the default size); full stays high meanwhile.
// item time is set by the read-modify-write of the store, which has one write
// port and one read port: each pixel that lands on screen is read, then written,
// while an off-screen or outside-circle point skips the store; the engine also
// takes the item, sees the end of the primitive and hands back the result. a
// circle outline walks 8 points per step, a filled circle (2r+1)^2 points, a
// rectangle 2w+2h points and a glyph 35 points; a clear sweeps one store byte a
// cycle. a two-entry command queue and a two-entry result queue let the input
// and output sides stall on their own.
module monochrome_framebuffer_draw_engine #(
	parameter int SCREEN_WIDTH  = fmd_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = fmd_pkg::DEF_SCREEN_HEIGHT
) (
	input  logic              clk,
	input  logic              arst_n,
	// command side
	input  logic              push,
	output logic              full,
	input  logic [2:0]        op,
	input  logic signed [9:0] pos_x,
	input  logic signed [9:0] pos_y,
	input  logic [6:0]        radius,
	input  logic [7:0]        rect_width,
	input  logic [6:0]        rect_height,
	input  logic              color,
	input  logic [7:0]        char_code,
	input  logic [9:0]        byte_index,
	// result side
	output logic              empty,
	input  logic              pop,
	output logic [7:0]        read_byte,
	output logic [2:0]        done_op
);

	logic          front_full, clearing, take;
	logic          cmd_empty, cmd_pop;
	fmd_pkg::cmd_t cmd;
	logic          res_full, res_push;
	fmd_pkg::res_t res, res_out;

	// no item is taken while the reset sweep runs
	assign full = front_full || clearing;
	assign take = push && !full;

	fmd_front #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (take),
		.op         (op),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.radius     (radius),
		.rect_width (rect_width),
		.rect_height(rect_height),
		.color      (color),
		.char_code  (char_code),
		.byte_index (byte_index),
		.full       (front_full),
		.cmd_pop    (cmd_pop),
		.cmd        (cmd),
		.cmd_empty  (cmd_empty)
	);

	// engine with the frame store
	fmd_back #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res),
		.clearing (clearing)
	);

	// result queue decouples the engine from a slow consumer
	fmd_fifo #(
		.WIDTH($bits(fmd_pkg::res_t)),
		.DEPTH(2)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty)
	);

	assign read_byte = res_out.read_byte;
	assign done_op   = res_out.done_op;

endmodule

@@ hdl/fmd_checker.sv @@
// port-level checks of the draw engine, bound to the top level
// depends on fmd_pkg and assert_macros.svh
`include "assert_macros.svh"

module fmd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              push,
	input logic              full,
	input logic              empty,
	input logic              pop,
	input logic [7:0]        read_byte,
	input logic [2:0]        done_op
);

	// items taken but not yet returned
	logic [3:0] out_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
		end else if ((push && !full) && !(pop && !empty)) begin
			out_cnt_q <= out_cnt_q + 4'd1;
		end else if (!(push && !full) && (pop && !empty)) begin
			out_cnt_q <= out_cnt_q - 4'd1;
		end
	end

	`FMD_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(read_byte) && $stable(done_op))
	`FMD_ASSERT_IMP(a_rd_zero, !empty && done_op != fmd_pkg::OP_READ, read_byte == 8'd0)
	`FMD_ASSERT_IMP(a_no_extra, !empty, out_cnt_q != 4'd0)

endmodule

bind monochrome_framebuffer_draw_engine fmd_checker u_fmd_checker (.*);

@@ sim/tb.sv @@
// self-checking testbench for the monochrome frame buffer draw engine
// depends on fmd_pkg and monochrome_framebuffer_draw_engine; runs a directed table,
// then random drawing commands checked against a shadow frame store
`timescale 1ns / 1ps

module tb;

	localparam int W = fmd_pkg::DEF_SCREEN_WIDTH;
	localparam int H = fmd_pkg::DEF_SCREEN_HEIGHT;
	localparam int STORE = W * ((H + 7) / 8);
	localparam int RANDOM_ITEMS = 1420;
	localparam int CALM_ITEMS = 150;
	localparam int IDLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 200;
	localparam logic [2:0] OP_NONE = 3'd7;

	// 5x7 font, five column bytes per glyph, bit = row
	localparam logic [39:0] FONT [38] = '{
		40'h00_00_00_00_00, 40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46,
		40'h21_41_45_4B_31, 40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30,
		40'h01_71_09_05_03, 40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h7E_11_11_11_7E,
		40'h7F_49_49_49_36, 40'h3E_41_41_41_22, 40'h7F_41_41_22_1C, 40'h7F_49_49_49_41,
		40'h7F_09_09_09_01, 40'h3E_41_49_49_7A, 40'h7F_08_08_08_7F, 40'h00_41_7F_41_00,
		40'h20_40_41_3F_01, 40'h7F_08_14_22_41, 40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F,
		40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E, 40'h7F_09_09_09_06, 40'h3E_41_51_21_5E,
		40'h7F_09_19_29_46, 40'h46_49_49_49_31, 40'h01_01_7F_01_01, 40'h3F_40_40_40_3F,
		40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F, 40'h63_14_08_14_63, 40'h07_08_70_08_07,
		40'h61_51_49_45_43, 40'h00_60_60_00_00
	};

	typedef struct {
		logic [2:0]        op;
		logic signed [9:0] x;
		logic signed [9:0] y;
		logic [6:0]        r;
		logic [7:0]        w;
		logic [6:0]        h;
		logic              c;
		logic [7:0]        code;
		logic [9:0]        idx;
		bit                typed;
		logic [7:0]        typed_byte;
	} row_t;

	typedef struct {
		logic [7:0] rbyte;
		logic [2:0] rop;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [2:0] op = '0;
	logic signed [9:0] pos_x = '0;
	logic signed [9:0] pos_y = '0;
	logic [6:0] radius = '0;
	logic [7:0] rect_width = '0;
	logic [6:0] rect_height = '0;
	logic color = 1'b0;
	logic [7:0] char_code = '0;
	logic [9:0] byte_index = '0;
	logic empty;
	logic pop = 1'b0;
	logic [7:0] read_byte;
	logic [2:0] done_op;

	// shadow copy of the frame store and the results still owed by the block
	logic [7:0] shadow_store [STORE];
	result_t owed_results [$];
	int mismatches = 0;
	bit calm = 1'b0;
	int stall_left = 0;
	int idle_cycles = 0;

	monochrome_framebuffer_draw_engine dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .op(op), .pos_x(pos_x), .pos_y(pos_y),
		.radius(radius), .rect_width(rect_width), .rect_height(rect_height),
		.color(color), .char_code(char_code), .byte_index(byte_index),
		.empty(empty), .pop(pop), .read_byte(read_byte), .done_op(done_op)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// ---- shadow drawing primitives ----
	function automatic void put_pixel(input int x, input int y, input bit on);
		int idx;
		if (x < 0 || x >= W || y < 0 || y >= H) return;
		idx = x + (y / 8) * W;
		if (on) shadow_store[idx][y % 8] = 1'b1;
		else shadow_store[idx][y % 8] = 1'b0;
	endfunction

	function automatic void draw_ring(input int cx, input int cy, input int r, input bit on);
		int x, y, e;
		x = r;
		y = 0;
		e = 0;
		while (x >= y) begin
			put_pixel(cx + x, cy + y, on);
			put_pixel(cx + y, cy + x, on);
			put_pixel(cx - y, cy + x, on);
			put_pixel(cx - x, cy + y, on);
			put_pixel(cx - x, cy - y, on);
			put_pixel(cx - y, cy - x, on);
			put_pixel(cx + y, cy - x, on);
			put_pixel(cx + x, cy - y, on);
			y++;
			e += 1 + 2 * y;
			// step inward once the error crosses the midpoint
			if (2 * e - 2 * x + 1 > 0) begin
				x--;
				e += 1 - 2 * x;
			end
		end
	endfunction

	function automatic void draw_disc(input int cx, input int cy, input int r, input bit on);
		for (int dy = -r; dy <= r; dy++)
			for (int dx = -r; dx <= r; dx++)
				if (dx * dx + dy * dy <= r * r) put_pixel(cx + dx, cy + dy, on);
	endfunction

	function automatic void draw_box(input int x0, input int y0, input int w, input int h,
			input bit on);
		for (int i = x0; i < x0 + w; i++) begin
			put_pixel(i, y0, on);
			put_pixel(i, y0 + h - 1, on);
		end
		for (int i = y0; i < y0 + h; i++) begin
			put_pixel(x0, i, on);
			put_pixel(x0 + w - 1, i, on);
		end
	endfunction

	function automatic void draw_char(input int x0, input int y0, input logic [7:0] code);
		int s;
		logic [7:0] colbits;
		s = 0;
		if (code >= "0" && code <= "9") s = 1 + int'(code) - int'("0");
		else if (code >= "A" && code <= "Z") s = 11 + int'(code) - int'("A");
		else if (code == ".") s = 37;
		for (int c = 0; c < 5; c++) begin
			colbits = FONT[s][39 - 8 * c -: 8];
			for (int r = 0; r < 7; r++) put_pixel(x0 + c, y0 + r, colbits[r]);
		end
	endfunction

	// applies one accepted command to the shadow store and returns its result
	function automatic result_t apply_command(input row_t cmd);
		result_t res;
		int px, py;
		px = cmd.x;
		py = cmd.y;
		res.rbyte = 8'h00;
		res.rop = cmd.op;
		case (cmd.op)
			fmd_pkg::OP_CLEAR: foreach (shadow_store[i]) shadow_store[i] = 8'h00;
			fmd_pkg::OP_PIXEL: put_pixel(px, py, cmd.c);
			fmd_pkg::OP_CIRCLE: draw_ring(px, py, cmd.r, cmd.c);
			fmd_pkg::OP_FILL: draw_disc(px, py, cmd.r, cmd.c);
			fmd_pkg::OP_RECT: draw_box(px, py, cmd.w, cmd.h, cmd.c);
			fmd_pkg::OP_GLYPH: draw_char(px, py, cmd.code);
			fmd_pkg::OP_READ: if (cmd.idx < STORE) res.rbyte = shadow_store[cmd.idx];
			default: ;
		endcase
		return res;
	endfunction

	// drives one command and holds it until the block takes it
	task automatic send(input row_t cmd);
		result_t res;
		push <= 1'b1;
		op <= cmd.op;
		pos_x <= cmd.x;
		pos_y <= cmd.y;
		radius <= cmd.r;
		rect_width <= cmd.w;
		rect_height <= cmd.h;
		color <= cmd.c;
		char_code <= cmd.code;
		byte_index <= cmd.idx;
		do @(posedge clk); while (full);
		res = apply_command(cmd);
		// typed rows carry their own expected byte
		if (cmd.typed) res.rbyte = cmd.typed_byte;
		owed_results.push_back(res);
	endtask

	task automatic sender_idle();
		int n;
		n = $urandom_range(1, 13);
		push <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic signed [9:0] coord(input int span);
		int v;
		// mostly near the screen, sometimes anywhere in the field
		if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 1023);
		else v = $urandom_range(0, span + 40) - 20;
		return 10'(v);
	endfunction

	function automatic row_t random_command();
		row_t cmd;
		int pick;
		cmd.typed = 1'b0;
		cmd.typed_byte = '0;
		cmd.x = coord(W);
		cmd.y = coord(H);
		cmd.c = 1'($urandom_range(0, 3) != 0);
		cmd.code = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 1)) cmd.code = 8'($urandom_range(8'h2E, 8'h5A));
		cmd.idx = 10'($urandom_range(0, 1023));
		cmd.w = 8'($urandom_range(0, 40));
		cmd.h = 7'($urandom_range(0, 30));
		if ($urandom_range(0, 19) == 0) begin
			cmd.w = 8'($urandom_range(0, 255));
			cmd.h = 7'($urandom_range(0, 127));
		end
		cmd.r = 7'($urandom_range(0, 12));
		pick = $urandom_range(0, 99);
		if (pick < 2) cmd.op = fmd_pkg::OP_CLEAR;
		else if (pick < 22) cmd.op = fmd_pkg::OP_PIXEL;
		else if (pick < 34) cmd.op = fmd_pkg::OP_CIRCLE;
		else if (pick < 42) cmd.op = fmd_pkg::OP_FILL;
		else if (pick < 54) cmd.op = fmd_pkg::OP_RECT;
		else if (pick < 66) cmd.op = fmd_pkg::OP_GLYPH;
		else if (pick < 98) cmd.op = fmd_pkg::OP_READ;
		else cmd.op = OP_NONE;
		// wide outlines are cheap, so the top radius bits get exercised there
		if (cmd.op == fmd_pkg::OP_CIRCLE && $urandom_range(0, 9) == 0)
			cmd.r = 7'($urandom_range(0, 127));
		if (cmd.op == fmd_pkg::OP_FILL && $urandom_range(0, 19) == 0)
			cmd.r = 7'($urandom_range(0, 30));
		return cmd;
	endfunction

	function automatic row_t mk(input logic [2:0] o, input int x, input int y, input int r,
			input int w, input int h, input bit c, input int code, input int idx,
			input bit typed = 1'b0, input int tb_byte = 0);
		row_t cmd;
		cmd.op = o;
		cmd.x = 10'(x);
		cmd.y = 10'(y);
		cmd.r = 7'(r);
		cmd.w = 8'(w);
		cmd.h = 7'(h);
		cmd.c = c;
		cmd.code = 8'(code);
		cmd.idx = 10'(idx);
		cmd.typed = typed;
		cmd.typed_byte = 8'(tb_byte);
		return cmd;
	endfunction

	// ---- stimulus ----
	initial begin
		row_t directed [$];
		foreach (shadow_store[i]) shadow_store[i] = 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// store reads as zero after reset, at both ends
		directed.push_back(mk(fmd_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8'h00));
		directed.push_back(mk(fmd_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 1023, 1, 8'h00));
		// corner pixels and clipped extremes
		directed.push_back(mk(fmd_pkg::OP_PIXEL, 0, 0, 0, 0, 0, 1, 0, 0));
		directed.push_back(mk(fmd_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8'h01));
		directed.push_back(mk(fmd_pkg::OP_PIXEL, 127, 63, 0, 0, 0, 1, 0, 0));
		directed.push_back(mk(fmd_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 1023, 1, 8'h80));
		directed.push_back(mk(fmd_pkg::OP_PIXEL, -512, -512, 0, 0, 0, 1, 0, 0));
		directed.push_back(mk(fmd_pkg::OP_PIXEL, 511, 511, 0, 0, 0, 1, 0, 0));
		directed.push_back(mk(fmd_pkg::OP_PIXEL, 128, 0, 0, 0, 0, 1, 0, 0));
		directed.push_back(mk(fmd_pkg::OP_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk(fmd_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8'h00));
		// glyphs: a digit, a letter at the edge, the dot, an unknown code as blank
		directed.push_back(mk(fmd_pkg::OP_GLYPH, 0, 0, 0, 0, 0, 0, "0", 0));
		directed.push_back(mk(fmd_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8'h3E));
		directed.push_back(mk(fmd_pkg::OP_GLYPH, 125, 60, 0, 0, 0, 0, "Z", 0));
		directed.push_back(mk(fmd_pkg::OP_GLYPH, 60, 30, 0, 0, 0, 1, ".", 0));
		directed.push_back(mk(fmd_pkg::OP_GLYPH, 0, 0, 0, 0, 0, 1, 8'hFF, 0));
		directed.push_back(mk(fmd_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8'h00));
		// zero-width rectangle still draws two vertical edges
		directed.push_back(mk(fmd_pkg::OP_RECT, 10, 8, 0, 0, 3, 1, 0, 0));
		directed.push_back(mk(fmd_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 138, 1, 8'h07));
		directed.push_back(mk(fmd_pkg::OP_RECT, 20, 20, 0, 255, 0, 1, 0, 0));
		directed.push_back(mk(fmd_pkg::OP_RECT, -5, -5, 0, 255, 127, 1, 0, 0));
		// zero radius plots the center; largest radius in both forms
		directed.push_back(mk(fmd_pkg::OP_CIRCLE, 64, 32, 0, 0, 0, 1, 0, 0));
		directed.push_back(mk(fmd_pkg::OP_FILL, 30, 30, 0, 0, 0, 1, 0, 0));
		directed.push_back(mk(fmd_pkg::OP_CIRCLE, 64, 32, 127, 0, 0, 1, 0, 0));
		directed.push_back(mk(fmd_pkg::OP_FILL, 64, 32, 127, 0, 0, 0, 0, 0));
		// unused op code changes nothing
		directed.push_back(mk(OP_NONE, 0, 0, 0, 0, 0, 1, 0, 0, 1, 8'h00));
		directed.push_back(mk(fmd_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk(fmd_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8'h00));

		foreach (directed[i]) begin
			if (i % 4 == 3) sender_idle();
			send(directed[i]);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// hold off once until the block has drained
			if (n == RANDOM_ITEMS / 2) begin
				push <= 1'b0;
				while (owed_results.size() != 0) @(posedge clk);
			end
			if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
			if (!calm && $urandom_range(0, 3) == 0) sender_idle();
			send(random_command());
		end
		push <= 1'b0;

		while (owed_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

	// ---- result side: check, then choose the next pop ----
	always @(posedge clk) begin
		result_t want;
		if (pop && !empty) begin
			if (owed_results.size() == 0) begin
				report("unexpected item", done_op, 0);
			end else begin
				want = owed_results.pop_front();
				if (read_byte !== want.rbyte) report("read_byte", read_byte, want.rbyte);
				if (done_op !== want.rop) report("done_op", done_op, want.rop);
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			pop <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 12);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule

@@ monochrome_framebuffer_draw_engine.f @@
+incdir+hdl
hdl/fmd_pkg.sv
hdl/fmd_ram.sv
hdl/fmd_fifo.sv
hdl/fmd_front.sv
hdl/fmd_back.sv
hdl/monochrome_framebuffer_draw_engine.sv
hdl/fmd_checker.sv
sim/tb.sv
